### rtl/bfz_pkg.sv
`default_nettype none

package bfz_pkg;

  // Store geometry
  localparam int MAX_BITS   = 1024;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORD_COUNT);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int CNT_W      = $clog2(WORD_COUNT + 1);
  localparam int POS_W      = WORD_AW + BIT_AW;

  // Field widths
  localparam int ACT_W = 3;
  localparam int IDX_W = 10;
  localparam int CAP_W = 11;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FIND  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RW,
    ST_SWEEP,
    ST_FIND,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### rtl/bfz_if.sv
`default_nettype none

interface bfz_in_if;
  import bfz_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IDX_W-1:0] index;
  logic             value;

  modport source (output valid, output action, output index, output value, input ready);
  modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface bfz_out_if;
  import bfz_pkg::*;
  logic             valid;
  logic             ready;
  logic             bit_value;
  logic             found;
  logic [IDX_W-1:0] found_index;
  logic             range_err;

  modport source (output valid, output bit_value, output found, output found_index,
                  output range_err, input ready);
  modport sink   (input valid, input bit_value, input found, input found_index,
                  input range_err, output ready);
endinterface

interface bfz_cfg_if;
  import bfz_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/bitmap_with_find_first_zero_top.sv
`default_nettype none

// Channel   | Dir | Payload                                          | Handshake
// in_req    | in  | action[2:0], index[9:0], value                   | valid/ready
// out_rsp   | out | bit_value, found, found_index[9:0], range_err    | valid/ready
// cfg_wr    | in  | data[10:0] = capacity                            | valid/ready
//
// One request at a time. Read/write: accept issues the registered read of the
// word store, then modify/write in RW, result register loaded in FIN. Clear/set
// all: one store write per cycle over the words in use. Find: one word read per
// cycle through the single store read port.
// Reset (rst_n low, sync) empties the store via per-word valid bits; no sweep.
// in_req.ready is high only in IDLE; a held result in out_rsp stalls the
// sequencer at its final step, the next request is taken once it is loaded.

module bitmap_with_find_first_zero_top (
  input  logic       clk,
  input  logic       rst_n,
  bfz_in_if.sink     in_req,
  bfz_out_if.source  out_rsp,
  bfz_cfg_if.sink    cfg_wr
);
  import bfz_pkg::*;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic [CAP_W-1:0] clip_cap(input logic [CAP_W-1:0] c);
    return (c > CAP_W'(MAX_BITS)) ? CAP_W'(MAX_BITS) : c;
  endfunction

  // ceil(capacity / WORD_BITS), capacity clipped to MAX_BITS
  function automatic logic [CNT_W-1:0] words_of(input logic [CAP_W-1:0] c);
    logic [CAP_W:0] s;
    s = {1'b0, clip_cap(c)} + (CAP_W + 1)'(WORD_BITS - 1);
    return CNT_W'(s >> BIT_AW);
  endfunction

  // lowest zero bit of a word: binary narrowing, one level per address bit
  function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] lo_mask;
    logic [BIT_AW-1:0]    pos;
    int                   h;
    v   = ~w;
    pos = '0;
    for (int l = BIT_AW - 1; l >= 0; l--) begin
      h       = 1 << l;
      lo_mask = {WORD_BITS{1'b1}} >> (WORD_BITS - h);
      if ((v & lo_mask) == '0) begin
        pos[l] = 1'b1;
        v      = v >> h;
      end
    end
    return pos;
  endfunction

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [CAP_W-1:0]      cap_eff;
  logic [CNT_W-1:0]      nwords;

  logic [ACT_W-1:0]      act_r, act_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  val_r, val_nxt;

  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [WORD_AW-1:0]    chk_w_r, chk_w_nxt;

  logic                  res_bit_r, res_bit_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [IDX_W-1:0]      res_fidx_r, res_fidx_nxt;
  logic                  res_oor_r, res_oor_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_bit_r, out_bit_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [IDX_W-1:0]      out_fidx_r, out_fidx_nxt;
  logic                  out_oor_r, out_oor_nxt;

  // word store: flops valid per word, data in an array with a registered read
  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] wvalid_r, wvalid_nxt;
  logic [WORD_BITS-1:0]  rdata_r;
  logic                  rvalid_r;
  logic [WORD_BITS-1:0]  rword;
  logic [WORD_AW-1:0]    raddr;
  logic                  mem_we;
  logic [WORD_AW-1:0]    waddr;
  logic [WORD_BITS-1:0]  wdata;

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  out_free;
  logic                  in_oor;
  logic                  find_issue;
  logic                  find_hit;
  logic [POS_W-1:0]      find_pos;
  logic [CNT_W-1:0]      old_words;
  logic [CNT_W-1:0]      new_words;
  logic [CNT_W-1:0]      ptr_inc;

  // ---------------------------------------------------------------------------
  // Handshakes and shared decode
  // ---------------------------------------------------------------------------
  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign in_acc       = in_req.valid & in_req.ready;
  assign cfg_acc      = cfg_wr.valid & cfg_wr.ready;
  assign out_free     = ~out_valid_r | out_rsp.ready;

  assign cap_eff   = clip_cap(cap_r);
  assign nwords    = words_of(cap_r);
  assign old_words = nwords;
  assign new_words = words_of(cfg_wr.data);
  assign in_oor    = {1'b0, in_req.index} >= cap_eff;
  assign ptr_inc   = ptr_r + CNT_W'(1);

  // never-written words read as zero
  assign rword = rvalid_r ? rdata_r : '0;

  // find: the compare stage works on the read issued in the cycle before
  assign find_issue = ptr_r < nwords;
  assign find_hit   = chk_vld_r & (rword != {WORD_BITS{1'b1}});
  assign find_pos   = {chk_w_r, lowest_zero(rword)};

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.bit_value   = out_bit_r;
  assign out_rsp.found       = out_found_r;
  assign out_rsp.found_index = out_fidx_r;
  assign out_rsp.range_err   = out_oor_r;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req.action) inside
            ACT_READ, ACT_WRITE: state_nxt = in_oor ? ST_FIN : ST_RW;
            ACT_CLEAR, ACT_SET:  state_nxt = (nwords == '0) ? ST_FIN : ST_SWEEP;
            ACT_FIND:            state_nxt = ST_FIND;
            default:             state_nxt = ST_FIN;
          endcase
        end
      end
      ST_RW:    state_nxt = ST_FIN;
      ST_SWEEP: if (ptr_inc >= nwords) state_nxt = ST_FIN;
      ST_FIND:  if (find_hit || !find_issue) state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    chk_vld_nxt   = chk_vld_r;
    chk_w_nxt     = chk_w_r;
    res_bit_nxt   = res_bit_r;
    res_found_nxt = res_found_r;
    res_fidx_nxt  = res_fidx_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r & ~out_rsp.ready;
    out_bit_nxt   = out_bit_r;
    out_found_nxt = out_found_r;
    out_fidx_nxt  = out_fidx_r;
    out_oor_nxt   = out_oor_r;
    raddr         = ptr_r[WORD_AW-1:0];
    mem_we        = 1'b0;
    waddr         = idx_r[IDX_W-1 -: WORD_AW];
    wdata         = rword;
    cap_nxt       = cfg_acc ? cfg_wr.data : cap_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt       = in_req.action;
          idx_nxt       = in_req.index;
          val_nxt       = in_req.value;
          raddr         = in_req.index[IDX_W-1 -: WORD_AW];
          ptr_nxt       = (in_req.action == ACT_FIND)
                          ? CNT_W'(in_req.index >> BIT_AW) : '0;
          chk_vld_nxt   = 1'b0;
          res_bit_nxt   = 1'b0;
          res_found_nxt = 1'b0;
          res_fidx_nxt  = '0;
          res_oor_nxt   = ((in_req.action == ACT_READ) || (in_req.action == ACT_WRITE))
                          && in_oor;
        end
      end
      ST_RW: begin
        if (act_r == ACT_READ) begin
          res_bit_nxt = rword[idx_r[BIT_AW-1:0]];
        end else begin
          mem_we                   = 1'b1;
          wdata[idx_r[BIT_AW-1:0]] = val_r;
        end
      end
      ST_SWEEP: begin
        mem_we  = 1'b1;
        waddr   = ptr_r[WORD_AW-1:0];
        wdata   = (act_r == ACT_SET) ? {WORD_BITS{1'b1}} : '0;
        ptr_nxt = ptr_inc;
      end
      ST_FIND: begin
        if (find_hit) begin
          // a zero past the capacity in the last word does not count
          if ({1'b0, find_pos} < cap_eff) begin
            res_found_nxt = 1'b1;
            res_fidx_nxt  = IDX_W'(find_pos);
          end
        end
        chk_vld_nxt = find_issue;
        chk_w_nxt   = ptr_r[WORD_AW-1:0];
        if (find_issue) ptr_nxt = ptr_inc;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = res_bit_r;
          out_found_nxt = res_found_r;
          out_fidx_nxt  = res_fidx_r;
          out_oor_nxt   = res_oor_r;
        end
      end
      default: ;
    endcase
  end

  // word valid bits: set on any store write, cleared for words that come
  // into use when the capacity grows
  always_comb begin
    wvalid_nxt = wvalid_r;
    if (mem_we) wvalid_nxt[waddr] = 1'b1;
    if (cfg_acc) begin
      for (int i = 0; i < WORD_COUNT; i++) begin
        if ((CNT_W'(i) >= old_words) && (CNT_W'(i) < new_words)) wvalid_nxt[i] = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= '0;
      wvalid_r    <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      wvalid_r    <= wvalid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    chk_w_r     <= chk_w_nxt;
    res_bit_r   <= res_bit_nxt;
    res_found_r <= res_found_nxt;
    res_fidx_r  <= res_fidx_nxt;
    res_oor_r   <= res_oor_nxt;
    out_bit_r   <= out_bit_nxt;
    out_found_r <= out_found_nxt;
    out_fidx_r  <= out_fidx_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  // word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r  <= mem[raddr];
    rvalid_r <= wvalid_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/bfz_checker.sv
`default_nettype none

module bfz_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      bit_value,
  input logic                      found,
  input logic [bfz_pkg::IDX_W-1:0] found_index,
  input logic                      range_err
);
  import bfz_pkg::*;

  // one request in flight: the port closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(found_index) && $stable(found)
                                   && $stable(bit_value) && $stable(range_err)))
    else $error("result changed while stalled");

  // an out-of-range request reports nothing else
  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && range_err) |-> (!bit_value && !found))
    else $error("range error result carries data");

  // find index is zero unless found
  a_fidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !found) |-> (found_index == '0))
    else $error("found_index set without found");

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitmap_with_find_first_zero_top bfz_checker u_bfz_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .bit_value   (out_rsp.bit_value),
  .found       (out_rsp.found),
  .found_index (out_rsp.found_index),
  .range_err   (out_rsp.range_err)
);

`default_nettype wire
